>>> rtl/core/heater_hysteresis_duty_control_assert.svh
// Assertion macros shared by the heater control RTL.
// Each macro expects a clock named clk and an active high reset named rst in scope.
`ifndef HEATER_HYSTERESIS_DUTY_CONTROL_ASSERT_SVH
`define HEATER_HYSTERESIS_DUTY_CONTROL_ASSERT_SVH

// Same-cycle implication.
`define HHDC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hhdc assertion failed");

// Next-cycle implication.
`define HHDC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hhdc assertion failed");

`endif

>>> rtl/core/hhdc_pkg.sv
// Package for the heater hysteresis and duty cycle controller.
// Holds item and state types, register indexes and constants; no dependencies.
package hhdc_pkg;

  localparam logic [7:0]  ContinuousCode = 8'hF0;
  localparam logic [15:0] StartupMin     = 16'd1000;

  typedef enum logic [1:0] {
    CfgUpperLimit = 2'd0,
    CfgLowerLimit = 2'd1,
    CfgOnSeconds  = 2'd2,
    CfgOffSeconds = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] upper_limit;
    logic [7:0] lower_limit;
    logic [7:0] on_seconds;
    logic [7:0] off_seconds;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  bottom_temp;
    logic        second_tick;
    logic        power_lost;
    logic [15:0] startup_delay;
    logic        top_request;
    logic        middle_request;
  } in_item_t;

  typedef struct packed {
    logic        bottom_heater;
    logic        top_heater;
    logic        middle_heater;
    logic [15:0] relay_on_seconds;
    logic        heating_phase;
  } out_item_t;

  typedef struct packed {
    logic        target_reached;
    logic [7:0]  active_on_time;
    logic [7:0]  active_off_time;
    logic        phase_flag;
    logic [7:0]  phase_counter;
    logic [15:0] relay_seconds;
    logic        bottom_drive;
  } ctrl_state_t;

  // Handshake control from the input stage to the rest of the pipe.
  typedef struct packed {
    logic valid;
    logic advance;
  } pipe_ctrl_t;

endpackage

>>> rtl/core/hhdc_in_if.sv
// Input item channel of the heater controller.
// Standalone interface with source and sink modports.
interface hhdc_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  bottom_temp;
  logic        second_tick;
  logic        power_lost;
  logic [15:0] startup_delay;
  logic        top_request;
  logic        middle_request;

  modport source (output valid, bottom_temp, second_tick, power_lost, startup_delay,
                  top_request, middle_request, input ready);
  modport sink (input valid, bottom_temp, second_tick, power_lost, startup_delay,
                top_request, middle_request, output ready);
endinterface

>>> rtl/core/hhdc_out_if.sv
// Result item channel of the heater controller.
// Standalone interface with source and sink modports.
interface hhdc_out_if;
  logic        valid;
  logic        ready;
  logic        bottom_heater;
  logic        top_heater;
  logic        middle_heater;
  logic [15:0] relay_on_seconds;
  logic        heating_phase;

  modport source (output valid, bottom_heater, top_heater, middle_heater,
                  relay_on_seconds, heating_phase, input ready);
  modport sink (input valid, bottom_heater, top_heater, middle_heater,
                relay_on_seconds, heating_phase, output ready);
endinterface

>>> rtl/core/hhdc_cfg_if.sv
// Configuration write channel of the heater controller.
// Standalone interface: register index plus 8-bit write data.
interface hhdc_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/hhdc_cfg_regs.sv
// Configuration register file of the heater controller.
// Depends on hhdc_pkg and hhdc_cfg_if.
module hhdc_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  hhdc_cfg_if.sink        cfg,
  output hhdc_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (cfg.valid) begin
      unique case (hhdc_pkg::cfg_idx_t'(cfg.index))
        hhdc_pkg::CfgUpperLimit: regs.upper_limit <= cfg.data;
        hhdc_pkg::CfgLowerLimit: regs.lower_limit <= cfg.data;
        hhdc_pkg::CfgOnSeconds:  regs.on_seconds  <= cfg.data;
        hhdc_pkg::CfgOffSeconds: regs.off_seconds <= cfg.data;
      endcase
    end
  end

endmodule

>>> rtl/core/hhdc_in_reg.sv
// Input register stage of the heater controller; owns the pipe handshake.
// Depends on hhdc_pkg and hhdc_in_if.
module hhdc_in_reg (
  input  logic                  clk,
  input  logic                  rst,
  hhdc_in_if.sink               in_ch,
  input  logic                  out_busy,
  output hhdc_pkg::in_item_t    item,
  output hhdc_pkg::pipe_ctrl_t  ctrl
);

  logic item_valid;

  // Advance when the result register is free or being drained this cycle.
  assign ctrl.valid   = item_valid;
  assign ctrl.advance = item_valid && !out_busy;
  assign in_ch.ready  = !item_valid || !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ch.ready) begin
      item_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item.bottom_temp    <= in_ch.bottom_temp;
      item.second_tick    <= in_ch.second_tick;
      item.power_lost     <= in_ch.power_lost;
      item.startup_delay  <= in_ch.startup_delay;
      item.top_request    <= in_ch.top_request;
      item.middle_request <= in_ch.middle_request;
    end
  end

endmodule

>>> rtl/core/hhdc_ctrl.sv
// Thermostat and bottom heater duty cycle logic with its state registers.
// Depends on hhdc_pkg and heater_hysteresis_duty_control_assert.svh.
`include "heater_hysteresis_duty_control_assert.svh"

module hhdc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  hhdc_pkg::cfg_t        regs,
  input  hhdc_pkg::in_item_t    item,
  input  hhdc_pkg::pipe_ctrl_t  ctrl,
  output hhdc_pkg::out_item_t   result_next
);

  hhdc_pkg::ctrl_state_t state;
  hhdc_pkg::ctrl_state_t state_next;

  logic       forced_off;
  logic [7:0] counter_inc;

  assign forced_off  = item.power_lost || (item.startup_delay < hhdc_pkg::StartupMin);
  assign counter_inc = state.phase_counter + 8'd1;

  always_comb begin
    state_next = state;

    // Thermostat step.
    if (regs.upper_limit == 8'd0) begin
      state_next.active_on_time = 8'd0;
    end else if (item.second_tick) begin
      if (state.target_reached && (item.bottom_temp >= regs.lower_limit)) begin
        state_next.active_on_time = 8'd0;
      end else if (item.bottom_temp >= regs.upper_limit) begin
        state_next.target_reached = 1'b1;
        state_next.active_on_time = 8'd0;
      end else begin
        state_next.target_reached  = 1'b0;
        state_next.active_on_time  = regs.on_seconds;
        state_next.active_off_time = regs.off_seconds;
      end
    end

    // Heater step, on the freshly updated on/off times.
    if (forced_off) begin
      state_next.bottom_drive = 1'b0;
    end else if (state_next.active_on_time == 8'd0) begin
      state_next.bottom_drive  = 1'b0;
      state_next.phase_flag    = 1'b0;
      state_next.phase_counter = 8'd0;
    end else if (state_next.active_on_time == hhdc_pkg::ContinuousCode) begin
      state_next.bottom_drive  = 1'b1;
      state_next.phase_flag    = 1'b1;
      state_next.phase_counter = 8'd0;
      if (item.second_tick) begin
        state_next.relay_seconds = state.relay_seconds + 16'd1;
      end
    end else if (item.second_tick) begin
      state_next.phase_counter = counter_inc;
      if (state.phase_flag) begin
        if (counter_inc >= state_next.active_on_time) begin
          state_next.phase_flag    = 1'b0;
          state_next.phase_counter = 8'd0;
          state_next.bottom_drive  = 1'b0;
        end else begin
          state_next.bottom_drive  = 1'b1;
          state_next.relay_seconds = state.relay_seconds + 16'd1;
        end
      end else begin
        if (counter_inc >= state_next.active_off_time) begin
          state_next.phase_flag    = 1'b1;
          state_next.phase_counter = 8'd0;
          state_next.bottom_drive  = 1'b1;
          state_next.relay_seconds = state.relay_seconds + 16'd1;
        end else begin
          state_next.bottom_drive  = 1'b0;
        end
      end
    end
  end

  always_comb begin
    result_next.bottom_heater    = state_next.bottom_drive;
    result_next.top_heater       = item.top_request && !forced_off;
    result_next.middle_heater    = item.middle_request && !forced_off;
    result_next.relay_on_seconds = state_next.relay_seconds;
    result_next.heating_phase    = state_next.phase_flag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (ctrl.advance) begin
      state <= state_next;
    end
  end

  `HHDC_ASSERT_NEXT(a_forced_off_holds_count, ctrl.advance && forced_off,
    !state.bottom_drive && $stable(state.relay_seconds))
  `HHDC_ASSERT_NEXT(a_disabled_clears_on_time,
    ctrl.advance && (regs.upper_limit == 8'd0), state.active_on_time == 8'd0)
  `HHDC_ASSERT_NEXT(a_relay_count_steps_by_one, ctrl.advance,
    (state.relay_seconds == $past(state.relay_seconds)) ||
    (state.relay_seconds == 16'($past(state.relay_seconds) + 16'd1)))
  `HHDC_ASSERT_NEXT(a_state_holds_when_stalled, !ctrl.advance, $stable(state))
  `HHDC_ASSERT_NOW(a_advance_needs_item, ctrl.advance, ctrl.valid)

endmodule

>>> rtl/core/hhdc_out_reg.sv
// Result register of the heater controller, drives the result channel.
// Depends on hhdc_pkg and hhdc_out_if.
module hhdc_out_reg (
  input  logic                  clk,
  input  logic                  rst,
  input  hhdc_pkg::pipe_ctrl_t  ctrl,
  input  hhdc_pkg::out_item_t   result_next,
  output logic                  out_busy,
  hhdc_out_if.source            out_ch
);

  hhdc_pkg::out_item_t result;
  logic                result_valid;

  // Busy while a result waits and is not taken this cycle.
  assign out_busy = result_valid && !out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!out_busy) begin
      result_valid <= ctrl.advance;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      result <= result_next;
    end
  end

  assign out_ch.valid            = result_valid;
  assign out_ch.bottom_heater    = result.bottom_heater;
  assign out_ch.top_heater       = result.top_heater;
  assign out_ch.middle_heater    = result.middle_heater;
  assign out_ch.relay_on_seconds = result.relay_on_seconds;
  assign out_ch.heating_phase    = result.heating_phase;

endmodule

>>> rtl/core/heater_hysteresis_duty_control.sv
// Top level of the heater hysteresis and duty cycle controller.
// Depends on hhdc_pkg, the channel interfaces and the hhdc_* stage modules.
//
// Each input item is one pass of the control loop and yields exactly one result
// item. Throughput is one item per clock unless the result channel stalls; an item
// passes the input register and then the result register, with the thermostat and
// duty cycle update done in one combinational step between them. A stalled result
// channel holds the result register and the input register behind it; the state
// advances only when an item moves into the result register. Configuration writes
// are taken in every cycle and should be issued while no item is in flight. The
// bottom heater output holds between second ticks; power loss or a start-up delay
// below 1000 drives all heaters off without disturbing the phase or relay counts.
module heater_hysteresis_duty_control (
  input  logic        clk,
  input  logic        rst,
  hhdc_cfg_if.sink    cfg_ch,
  hhdc_in_if.sink     in_ch,
  hhdc_out_if.source  out_ch
);

  hhdc_pkg::cfg_t       regs;
  hhdc_pkg::in_item_t   item;
  hhdc_pkg::pipe_ctrl_t ctrl;
  hhdc_pkg::out_item_t  result_next;
  logic                 out_busy;

  hhdc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg_ch),
    .regs (regs)
  );

  hhdc_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch),
    .out_busy (out_busy),
    .item     (item),
    .ctrl     (ctrl)
  );

  hhdc_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .regs        (regs),
    .item        (item),
    .ctrl        (ctrl),
    .result_next (result_next)
  );

  hhdc_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (ctrl),
    .result_next (result_next),
    .out_busy    (out_busy),
    .out_ch      (out_ch)
  );

endmodule
